// ----- sv/fdc_pkg.sv -----
// Shared types, constants and the CRC16 byte update for the frame deframer.
// No dependencies; imported by every module of the block except fdc_ram.
`timescale 1ns / 1ps
`default_nettype none

package fdc_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int PAY_AW      = 5;
	localparam int LEN_W       = 6;
	localparam int TDATA_W     = 32;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'h0000;
	localparam logic [7:0]  SYNC_RST = 8'h02;

	typedef enum logic [2:0] {
		ST_SYNC,
		ST_LEN,
		ST_TYPE,
		ST_PAYLOAD,
		ST_CRC_H,
		ST_CRC_L,
		ST_DRAIN
	} fdc_state_t;

	typedef struct packed {
		logic load_len;
		logic load_type;
		logic take_byte;
		logic load_crc_h;
		logic start_drain;
		logic issue;
	} fdc_cmd_t;

	typedef struct packed {
		logic is_sync;
		logic len_too_big;
		logic len_zero;
		logic payload_done;
		logic crc_ok;
		logic issue_ok;
		logic drain_last;
	} fdc_status_t;

	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- sv/fdc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- sv/fdc_ctrl.sv -----
// Frame parser state machine: walks sync, length, type, payload, CRC and drain.
// Depends on fdc_pkg; drives fdc_dp through command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module fdc_ctrl
	import fdc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire fdc_status_t sts,
	output      fdc_cmd_t    cmd
);

	fdc_state_t state_q, state_d;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SYNC;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q != ST_DRAIN);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_SYNC: begin
				if (accept && sts.is_sync) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				if (accept) begin
					if (sts.len_too_big) begin
						state_d = ST_SYNC;
					end else begin
						cmd.load_len = 1'b1;
						state_d      = ST_TYPE;
					end
				end
			end
			ST_TYPE: begin
				if (accept) begin
					cmd.load_type = 1'b1;
					state_d       = sts.len_zero ? ST_CRC_H : ST_PAYLOAD;
				end
			end
			ST_PAYLOAD: begin
				if (accept) begin
					cmd.take_byte = 1'b1;
					if (sts.payload_done) begin
						state_d = ST_CRC_H;
					end
				end
			end
			ST_CRC_H: begin
				if (accept) begin
					cmd.load_crc_h = 1'b1;
					state_d        = ST_CRC_L;
				end
			end
			ST_CRC_L: begin
				if (accept) begin
					if (sts.crc_ok) begin
						cmd.start_drain = 1'b1;
						state_d         = ST_DRAIN;
					end else begin
						state_d = ST_SYNC;
					end
				end
			end
			ST_DRAIN: begin
				if (sts.issue_ok) begin
					cmd.issue = 1'b1;
					if (sts.drain_last) begin
						state_d = ST_SYNC;
					end
				end
			end
			default: begin
				state_d = ST_SYNC;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/fdc_dp.sv -----
// Deframer datapath: frame fields, running CRC, payload store, read stage
// and output register. Depends on fdc_pkg and fdc_ram.
`timescale 1ns / 1ps
`default_nettype none

module fdc_dp
	import fdc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	input  wire logic [7:0]         cfg_data,
	input  wire logic [7:0]         s_tdata,
	input  wire fdc_cmd_t           cmd,
	output      fdc_status_t        sts,
	output      logic               m_tvalid,
	input  wire logic               m_tready,
	output      logic [TDATA_W-1:0] m_tdata, // pkt_type, pkt_len, byte_index, data_byte
	output      logic               m_tuser, // has_data
	output      logic               m_tlast
);

	logic [7:0]       sync_q;
	logic [LEN_W-1:0] frame_length_q;
	logic [7:0]       frame_type_q;
	logic [LEN_W-1:0] bytes_taken_q;
	logic [7:0]       crc_high_q;
	logic [15:0]      crc_q;
	logic [PAY_AW-1:0] rd_idx_q;

	logic              s1_valid_q;
	logic [7:0]        type_s1;
	logic [LEN_W-1:0]  len_s1;
	logic [PAY_AW-1:0] idx_s1;
	logic              has_data_s1;
	logic              last_s1;

	logic              out_valid_q;
	logic [7:0]        out_type_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [PAY_AW-1:0] out_idx_q;
	logic [7:0]        out_data_q;
	logic              out_has_q;
	logic              out_last_q;

	logic [7:0]  ram_rdata;
	logic        out_load;
	logic [15:0] crc_next;
	logic [15:0] crc_base;

	fdc_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PAYLOAD)
	) u_ram (
		.clk  (clk),
		.we   (cmd.take_byte),
		.waddr(bytes_taken_q[PAY_AW-1:0]),
		.wdata(s_tdata),
		.re   (cmd.issue),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	assign crc_base = cmd.load_len ? CRC_INIT : crc_q;
	assign crc_next = crc_add(crc_base, s_tdata);
	assign out_load = s1_valid_q && (!out_valid_q || m_tready);

	always_comb begin
		sts              = '0;
		sts.is_sync      = (s_tdata == sync_q);
		sts.len_too_big  = (s_tdata > 8'(MAX_PAYLOAD));
		sts.len_zero     = (frame_length_q == '0);
		sts.payload_done = ((bytes_taken_q + LEN_W'(1)) >= frame_length_q);
		sts.crc_ok       = ({crc_high_q, s_tdata} == crc_q);
		sts.issue_ok     = !s1_valid_q || out_load;
		sts.drain_last   = (bytes_taken_q == '0) ||
		                   ((LEN_W'(rd_idx_q) + LEN_W'(1)) == bytes_taken_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RST;
		end else if (cfg_valid) begin
			sync_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_len) begin
			frame_length_q <= s_tdata[LEN_W-1:0];
		end
		if (cmd.load_type) begin
			frame_type_q  <= s_tdata;
			bytes_taken_q <= '0;
		end
		if (cmd.take_byte) begin
			bytes_taken_q <= bytes_taken_q + LEN_W'(1);
		end
		if (cmd.load_len || cmd.load_type || cmd.take_byte) begin
			crc_q <= crc_next;
		end
		if (cmd.load_crc_h) begin
			crc_high_q <= s_tdata;
		end
		if (cmd.start_drain) begin
			rd_idx_q <= '0;
		end else if (cmd.issue) begin
			rd_idx_q <= rd_idx_q + PAY_AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.issue) begin
				s1_valid_q <= 1'b1;
			end else if (out_load) begin
				s1_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			type_s1     <= frame_type_q;
			len_s1      <= bytes_taken_q;
			idx_s1      <= rd_idx_q;
			has_data_s1 <= (bytes_taken_q != '0);
			last_s1     <= sts.drain_last;
		end
		if (out_load) begin
			out_type_q <= type_s1;
			out_len_q  <= len_s1;
			out_idx_q  <= idx_s1;
			out_data_q <= has_data_s1 ? ram_rdata : 8'h00;
			out_has_q  <= has_data_s1;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_data_q, out_idx_q, out_len_q, out_type_q};
	assign m_tuser  = out_has_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- sv/frame_deframer_crc16_check_core.sv -----
// Frame deframer with CRC16 check: one received byte per beat, one result per cycle
// unless m_tready stalls. Input takes a byte every cycle except while a good frame
// drains out. Results pass the read stage and output register; N payload results
// (or one empty result) leave one per cycle from the payload RAM's single read port.
// Asynchronous active-low reset returns to sync hunting with sync byte 0x02.
`timescale 1ns / 1ps
`default_nettype none

module frame_deframer_crc16_check_core
	import fdc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output      logic               cfg_ready,
	input  wire logic [7:0]         cfg_data,  // sync_byte
	input  wire logic               s_tvalid,
	output      logic               s_tready,
	input  wire logic [7:0]         s_tdata,   // rx_byte
	output      logic               m_tvalid,
	input  wire logic               m_tready,
	output      logic [TDATA_W-1:0] m_tdata,   // pkt_type[7:0], pkt_len[13:8],
	                                           // byte_index[18:14], data_byte[26:19]
	output      logic               m_tuser,   // has_data
	output      logic               m_tlast
);

	fdc_cmd_t    cmd;
	fdc_status_t sts;

	assign cfg_ready = 1'b1;

	fdc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	fdc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ----- sv/fdc_checker.sv -----
// Port-level checks on the deframer result stream, bound to the top level.
// Depends on fdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdc_checker
	import fdc_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [TDATA_W-1:0] m_tdata,
	input wire logic               m_tuser,
	input wire logic               m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && (m_tdata[26:8] == 19'd0))
		else $error("empty-frame beat malformed");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> ({1'b0, m_tdata[18:14]} < m_tdata[13:8]))
		else $error("byte index beyond payload length");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tlast |-> (({1'b0, m_tdata[18:14]} + 6'd1) == m_tdata[13:8]))
		else $error("last beat not at final payload byte");

	a_next_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser && !m_tlast ##1 m_tvalid |->
		(m_tdata[18:14] == ($past(m_tdata[18:14]) + 5'd1)))
		else $error("payload beats out of order");

endmodule

bind frame_deframer_crc16_check_core fdc_checker u_fdc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

`default_nettype wire
